FILE: rtl/ajb_pkg.sv
// Shared constants, codes and types for the audio jitter buffer.
// No dependencies; imported by ajb_frame_store and audio_jitter_buffer.
package ajb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int FRAME_BYTES = 4;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LVL_W       = ADDR_W + 1;
  localparam int LANE_W      = $clog2(FRAME_BYTES);
  localparam int BANK_DEPTH  = STORE_BYTES / FRAME_BYTES;
  localparam int BANK_AW     = ADDR_W - LANE_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 3'd4;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_PULL = 2'd1;
  localparam logic [1:0] REQ_DISC = 2'd2;

  localparam logic [11:0] PRIME_LEVEL_RST  = 12'd1920;
  localparam logic [11:0] MAX_LEVEL_RST    = 12'd3840;
  localparam logic [17:0] SAMPLE_RATE_HZ   = 18'd48000;
  localparam logic [3:0]  CHANNELS_STEREO  = 4'd2;
  localparam logic [2:0]  PCM_SAMPLE_BYTES = 3'd2;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_head;
  } store_req_t;

endpackage

FILE: rtl/ajb_frame_store.sv
// Byte store of the jitter buffer: one bank per frame byte lane.
// Depends on ajb_pkg. Writes one byte, reads one whole frame at any byte offset.
module ajb_frame_store (
  input  logic                clk,
  input  ajb_pkg::store_req_t req,
  output ajb_pkg::frame_t     frame
);
  import ajb_pkg::*;

  logic [7:0]        bank_q_r [FRAME_BYTES];
  logic [LANE_W-1:0] lane_r;

  for (genvar b = 0; b < FRAME_BYTES; b++) begin : g_bank
    logic [7:0]         mem [BANK_DEPTH];
    logic [LANE_W-1:0]  off;
    logic [ADDR_W-1:0]  byte_addr;
    logic [BANK_AW-1:0] rd_addr;

    assign off       = LANE_W'(b) - req.rd_head[LANE_W-1:0];
    assign byte_addr = req.rd_head + ADDR_W'(off);
    assign rd_addr   = byte_addr[ADDR_W-1:LANE_W];

    always_ff @(posedge clk) begin
      if (req.wr_en && req.wr_addr[LANE_W-1:0] == LANE_W'(b)) begin
        mem[req.wr_addr[ADDR_W-1:LANE_W]] <= req.wr_data;
      end
      if (req.rd_en) begin
        bank_q_r[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      lane_r <= req.rd_head[LANE_W-1:0];
    end
  end

  always_comb begin
    logic [LANE_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      idx      = lane_r + LANE_W'(k);
      frame[k] = bank_q_r[idx];
    end
  end

endmodule

FILE: rtl/audio_jitter_buffer.sv
// Audio jitter buffer top level: byte FIFO for 16-bit stereo PCM with priming.
// Depends on ajb_pkg and ajb_frame_store.
//
// Input channel (in_*): one request per transfer. A push appends in_data_byte,
// a pull asks for one frame, a disconnect empties the buffer and ends the block.
// Only a pull gives a result on the output channel (out_*): the two samples,
// a silence flag and the last-frame flag of the current block.
// Configuration (cfg_*): writes always taken, cfg_ready is tied high; write only
// while no request is in flight.
// A pull is registered first in the input stage, and its result then in the
// output stage, whose valid flag drives out_valid.
// Throughput: one request per cycle while in_stall is low; a push writes one
// byte lane, a pull reads all four store lanes at once: neither waits on memory.
// Reset empties the buffer, drops priming and loads the default configuration;
// store contents are not cleared. While out_stall is high the result holds and
// in_stall rises once a second pull is waiting behind it.
module audio_jitter_buffer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_req_type,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_block_start,
  input  logic [9:0]                           in_block_frames,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   out_left_sample,
  output logic signed [15:0]                   out_right_sample,
  output logic                                 out_silent,
  output logic                                 out_last_of_block,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ajb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ajb_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ajb_pkg::*;

  logic [11:0] prime_level_r, max_level_r;
  logic [17:0] sample_rate_r;
  logic [3:0]  channels_r;
  logic [2:0]  sample_bytes_r;

  logic        in_v_r;
  logic [1:0]  req_r;
  logic [7:0]  byte_r;
  logic        start_r;
  logic [9:0]  frames_in_r;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [LVL_W-1:0]  fill_r, fill_nxt;
  logic              primed_r, primed_nxt;
  logic              serving_r, serving_nxt;
  logic [9:0]        frames_r, frames_nxt;

  logic s2_v_r, s2_silent_r, s2_last_r;
  logic silent_c, last_c;

  logic is_pull, s2_free, s1_fire;
  store_req_t store_req;
  frame_t     frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_level_r  <= PRIME_LEVEL_RST;
      max_level_r    <= MAX_LEVEL_RST;
      sample_rate_r  <= SAMPLE_RATE_HZ;
      channels_r     <= CHANNELS_STEREO;
      sample_bytes_r <= PCM_SAMPLE_BYTES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIME_LEVEL:  prime_level_r  <= cfg_data[11:0];
        CFG_MAX_LEVEL:    max_level_r    <= cfg_data[11:0];
        CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_data[17:0];
        CFG_CHANNELS:     channels_r     <= cfg_data[3:0];
        CFG_SAMPLE_BYTES: sample_bytes_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign is_pull  = req_r == REQ_PULL;
  assign s2_free  = !s2_v_r || !out_stall;
  assign s1_fire  = in_v_r && (!is_pull || s2_free);
  assign in_stall = in_v_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req_r       <= in_req_type;
      byte_r      <= in_data_byte;
      start_r     <= in_block_start;
      frames_in_r <= in_block_frames;
    end
  end

  always_comb begin
    logic [ADDR_W-1:0] head1;
    logic [LVL_W-1:0]  fill1, excess, drop_n;
    logic [LVL_W:0]    rounded;
    logic [9:0]        bf;
    logic [LVL_W-1:0]  need;
    logic              fmt_ok;

    head_nxt    = head_r;
    fill_nxt    = fill_r;
    primed_nxt  = primed_r;
    serving_nxt = serving_r;
    frames_nxt  = frames_r;
    silent_c    = 1'b1;
    last_c      = 1'b0;
    store_req   = '0;
    store_req.wr_addr = head_r + fill_r[ADDR_W-1:0];
    store_req.wr_data = byte_r;
    store_req.rd_head = head_r;

    head1   = head_r;
    fill1   = fill_r;
    excess  = '0;
    rounded = '0;
    drop_n  = '0;
    bf      = (frames_in_r == '0) ? 10'd1 : frames_in_r;
    need    = LVL_W'(bf) << LANE_W;
    fmt_ok  = sample_bytes_r == PCM_SAMPLE_BYTES && channels_r == CHANNELS_STEREO &&
              sample_rate_r == SAMPLE_RATE_HZ;

    if (s1_fire) begin
      case (req_r)
        REQ_PUSH: begin
          store_req.wr_en = 1'b1;
          if (fill_r >= LVL_W'(STORE_BYTES)) begin
            head1 = head_r + ADDR_W'(FRAME_BYTES);
            fill1 = fill_r - LVL_W'(FRAME_BYTES - 1);
          end else begin
            fill1 = fill_r + 1'b1;
          end
          head_nxt = head1;
          fill_nxt = fill1;
          if (fill1 > {1'b0, max_level_r}) begin
            excess  = fill1 - {1'b0, max_level_r};
            rounded = ({1'b0, excess} + (LVL_W + 1)'(FRAME_BYTES - 1)) &
                      ~((LVL_W + 1)'(FRAME_BYTES - 1));
            drop_n  = (rounded > {1'b0, fill1}) ? fill1 : rounded[LVL_W-1:0];
            head_nxt = head1 + drop_n[ADDR_W-1:0];
            fill_nxt = fill1 - drop_n;
          end
        end
        REQ_PULL: begin
          if (start_r || frames_r == '0) begin
            frames_nxt  = bf;
            serving_nxt = 1'b0;
            if (!fmt_ok) begin
              head_nxt   = '0;
              fill_nxt   = '0;
              primed_nxt = 1'b0;
            end else if (primed_r || fill_r >= {1'b0, prime_level_r}) begin
              primed_nxt = 1'b1;
              if (fill_r < need) begin
                primed_nxt = 1'b0;
              end else begin
                serving_nxt = 1'b1;
              end
            end
          end
          store_req.rd_head = head_nxt;
          if (serving_nxt && fill_nxt >= LVL_W'(FRAME_BYTES)) begin
            store_req.rd_en = 1'b1;
            silent_c = 1'b0;
            head_nxt = head_nxt + ADDR_W'(FRAME_BYTES);
            fill_nxt = fill_nxt - LVL_W'(FRAME_BYTES);
          end
          frames_nxt = frames_nxt - 1'b1;
          if (frames_nxt == '0) begin
            serving_nxt = 1'b0;
            last_c      = 1'b1;
          end
        end
        REQ_DISC: begin
          head_nxt    = '0;
          fill_nxt    = '0;
          primed_nxt  = 1'b0;
          serving_nxt = 1'b0;
          frames_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      primed_r  <= 1'b0;
      serving_r <= 1'b0;
      frames_r  <= '0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      primed_r  <= primed_nxt;
      serving_r <= serving_nxt;
      frames_r  <= frames_nxt;
    end
  end

  ajb_frame_store u_store (
    .clk   (clk),
    .req   (store_req),
    .frame (frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_fire && is_pull) begin
      s2_v_r <= 1'b1;
    end else if (!out_stall) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_pull) begin
      s2_silent_r <= silent_c;
      s2_last_r   <= last_c;
    end
  end

  assign out_valid         = s2_v_r;
  assign out_silent        = s2_silent_r;
  assign out_last_of_block = s2_last_r;
  assign out_left_sample   = s2_silent_r ? 16'sd0 : {frame[1], frame[0]};
  assign out_right_sample  = s2_silent_r ? 16'sd0 : {frame[3], frame[2]};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LVL_W'(STORE_BYTES))
    else $error("fill level beyond store size");

  a_serve_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    serving_r |-> frames_r != '0 && primed_r)
    else $error("serving outside a primed block");

  a_disc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && req_r == REQ_DISC |=> fill_r == '0 && !primed_r && frames_r == '0)
    else $error("disconnect left state behind");

  a_read_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.rd_en |-> s2_free && !store_req.wr_en)
    else $error("store read while result stage occupied");

endmodule
